// ----- rtl/tmaf_pkg.sv -----
// Package with the constants shared by the trimmed-mean ADC filter.
package tmaf_pkg;

  localparam int unsigned ChannelCountDefault = 4;

  localparam int unsigned ChannelW = 2;
  localparam int unsigned SampleW  = 12;
  localparam int unsigned GainW    = 4;
  localparam int unsigned ValueW   = 15;
  localparam int unsigned CountW   = 4;
  localparam int unsigned SumW     = 16;
  localparam int unsigned MeanW    = SumW - 3;
  localparam int unsigned ProdW    = MeanW + GainW;

  // Block of ten samples, the smallest and largest dropped, eight kept.
  localparam logic [CountW-1:0]  LastCount  = CountW'(9);
  localparam int unsigned        KeptShift  = 3;
  localparam logic [SampleW-1:0] SampleMax  = '1;
  localparam logic [GainW-1:0]   GainReset  = GainW'(1);
  localparam logic [ValueW-1:0]  ValueMax   = '1;

  localparam int unsigned DataW  = 16;
  localparam int unsigned ApbAddrW = 2;
  localparam int unsigned ApbDataW = 32;

endpackage

// ----- rtl/trimmed_mean_adc_filter_core.sv -----
// Top level of the per-channel trimmed-mean (olympic) ADC filter.
//
//  channel     dir  width  accepted when                     content
//  s_axis      in   16+2   s_axis_tvalid & s_axis_tready     one ADC sample and its channel
//  m_axis      out  16+2   m_axis_tvalid & m_axis_tready     one filtered value and its channel
//  apb         in   2/32   psel & penable & pwrite & pready  output_gain register at address 0
//
// A sample transfer is taken into an input register. From there the channel's count,
// running sum, minimum and maximum are read, updated and written back, so a new sample can
// be taken every cycle, even for the same channel, unless a finished block waits for room.
// On the tenth sample of a channel the trimmed mean goes to a middle register, is
// multiplied by the gain and lands in the output register.
// Reset clears every channel's block and sets the gain to one. A stalled output only holds
// back a sample that completes a block while the middle and output registers are both full;
// while it waits, no new sample is taken.
module trimmed_mean_adc_filter_core #(
  parameter int unsigned CHANNEL_COUNT = tmaf_pkg::ChannelCountDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Sample stream.
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [tmaf_pkg::DataW-1:0]    s_axis_tdata,   // [11:0] sample, [15:12] zero
  input  logic [tmaf_pkg::ChannelW-1:0] s_axis_tuser,   // [1:0] channel
  // Result stream.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [tmaf_pkg::DataW-1:0]    m_axis_tdata,   // [14:0] filtered_value, [15] zero
  output logic [tmaf_pkg::ChannelW-1:0] m_axis_tuser,   // [1:0] out_channel
  // Configuration port.
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmaf_pkg::ApbAddrW-1:0] paddr,
  input  logic [tmaf_pkg::ApbDataW-1:0] pwdata,
  output logic [tmaf_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);
  import tmaf_pkg::*;

  // Wide enough to compare a channel number with any channel index in range.
  localparam int unsigned ChCmpW = 5;

  // Configuration. There is a single register, so the address is not decoded.
  logic [GainW-1:0] gain_q;
  logic             cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = {{(ApbDataW-GainW){1'b0}}, gain_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GainReset;
    end else if (cfg_write) begin
      gain_q <= pwdata[GainW-1:0];
    end
  end

  // Per-channel block state.
  logic [CountW-1:0]  count_q [CHANNEL_COUNT];
  logic [SumW-1:0]    sum_q   [CHANNEL_COUNT];
  logic [SampleW-1:0] min_q   [CHANNEL_COUNT];
  logic [SampleW-1:0] max_q   [CHANNEL_COUNT];

  // Pipeline registers.
  logic                r_valid_q;
  logic [ChannelW-1:0] r_ch_q;
  logic [SampleW-1:0]  r_sample_q;
  logic                p_valid_q;
  logic [ChannelW-1:0] p_ch_q;
  logic [MeanW-1:0]    p_mean_q;
  logic                o_valid_q;
  logic [ChannelW-1:0] o_ch_q;
  logic [ValueW-1:0]   o_value_q;

  // Read of the addressed channel's state.
  logic [CHANNEL_COUNT-1:0] hit;
  logic                     ch_present;
  logic [CountW-1:0]        cur_count;
  logic [SumW-1:0]          cur_sum;
  logic [SampleW-1:0]       cur_min;
  logic [SampleW-1:0]       cur_max;

  always_comb begin
    cur_count = '0;
    cur_sum   = '0;
    cur_min   = '0;
    cur_max   = '0;
    for (int c = 0; c < CHANNEL_COUNT; c++) begin
      hit[c] = ({{(ChCmpW-ChannelW){1'b0}}, r_ch_q} == ChCmpW'(c));
      if (hit[c]) begin
        cur_count = count_q[c];
        cur_sum   = sum_q[c];
        cur_min   = min_q[c];
        cur_max   = max_q[c];
      end
    end
  end

  assign ch_present = |hit;

  // Update of the block with the registered sample.
  logic [SumW-1:0]    new_sum;
  logic [SampleW-1:0] new_min;
  logic [SampleW-1:0] new_max;
  logic [SumW-1:0]    trimmed;
  logic               block_done;

  assign new_sum    = cur_sum + {{(SumW-SampleW){1'b0}}, r_sample_q};
  assign new_min    = (r_sample_q < cur_min) ? r_sample_q : cur_min;
  assign new_max    = (r_sample_q > cur_max) ? r_sample_q : cur_max;
  assign trimmed    = new_sum - {{(SumW-SampleW){1'b0}}, new_min}
                              - {{(SumW-SampleW){1'b0}}, new_max};
  assign block_done = ch_present && (cur_count == LastCount);

  // Handshake chain. A sample that completes no block never waits for the result side.
  logic o_free;
  logic p_free;
  logic r_go;
  logic s_take;

  assign o_free        = !o_valid_q || m_axis_tready;
  assign p_free        = !p_valid_q || o_free;
  assign r_go          = r_valid_q && (!block_done || p_free);
  assign s_axis_tready = !r_valid_q || r_go;
  assign s_take        = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        count_q[c] <= '0;
        sum_q[c]   <= '0;
        min_q[c]   <= SampleMax;
        max_q[c]   <= '0;
      end
    end else if (r_go) begin
      for (int c = 0; c < CHANNEL_COUNT; c++) begin
        if (hit[c]) begin
          if (block_done) begin
            count_q[c] <= '0;
            sum_q[c]   <= '0;
            min_q[c]   <= SampleMax;
            max_q[c]   <= '0;
          end else begin
            count_q[c] <= cur_count + CountW'(1);
            sum_q[c]   <= new_sum;
            min_q[c]   <= new_min;
            max_q[c]   <= new_max;
          end
        end
      end
    end
  end

  // Gain multiply with saturation to the output width.
  logic [ProdW-1:0] product;
  logic [ValueW-1:0] value_sat;

  assign product   = {{GainW{1'b0}}, p_mean_q} * {{MeanW{1'b0}}, gain_q};
  assign value_sat = (product > {{(ProdW-ValueW){1'b0}}, ValueMax}) ? ValueMax
                                                                    : product[ValueW-1:0];

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_valid_q <= 1'b0;
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        r_valid_q <= s_axis_tvalid;
      end
      if (p_free) begin
        p_valid_q <= r_go && block_done;
      end
      if (o_free) begin
        o_valid_q <= p_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s_take) begin
      r_ch_q     <= s_axis_tuser;
      r_sample_q <= s_axis_tdata[SampleW-1:0];
    end
    if (r_go && block_done) begin
      p_ch_q   <= r_ch_q;
      p_mean_q <= trimmed[SumW-1:KeptShift];
    end
    if (o_free && p_valid_q) begin
      o_ch_q    <= p_ch_q;
      o_value_q <= value_sat;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tuser  = o_ch_q;
  assign m_axis_tdata  = {{(DataW-ValueW){1'b0}}, o_value_q};

  // Assertions.
  a_gain_write : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write |=> prdata[GainW-1:0] == $past(pwdata[GainW-1:0]))
    else $error("gain register did not take the written value");

  a_done_needs_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (r_go && block_done) |-> p_free)
    else $error("finished block advanced into a full middle stage");

  for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_chk
    a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
      count_q[g] <= LastCount)
      else $error("channel sample count ran past the block length");

    a_min_le_max : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (count_q[g] != '0) |-> (min_q[g] <= max_q[g]))
      else $error("channel minimum above maximum in a started block");

    a_sum_covers : assert property (@(posedge clk_i) disable iff (!rst_ni)
      (count_q[g] > CountW'(1)) |->
        ({1'b0, sum_q[g]} >= ({5'b0, min_q[g]} + {5'b0, max_q[g]})))
      else $error("channel sum smaller than minimum plus maximum");
  end

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the per-channel trimmed-mean ADC filter core.
module tb_top;

  import tmaf_pkg::*;

  // One sample transfer as offered on the input stream.
  typedef struct packed {
    logic [ChannelW-1:0] channel;
    logic [SampleW-1:0]  sample;
  } adc_sample_t;

  // One filtered value as expected on the output stream.
  typedef struct packed {
    logic [ChannelW-1:0] channel;
    logic [ValueW-1:0]   value;
  } filtered_value_t;

  localparam logic [ApbAddrW-1:0] GainAddr   = '0;
  localparam logic [CountW-1:0]   BlockLen   = CountW'(10);
  localparam int unsigned         Channels   = ChannelCountDefault;
  // The margin lets a result pass the input, middle and output registers and covers a stalled output.
  localparam int unsigned         SettleWait = 8;
  localparam int unsigned         HoldCycles = 300;
  localparam int unsigned         IdleLimit  = 4000;
  localparam int unsigned         PhaseCount = 7;
  localparam int unsigned         PhaseItems = 75;
  // The receiver holds off during the phase that runs at gain 8.
  localparam int unsigned         HoldPhase  = 2;
  localparam int unsigned         GainPlan [PhaseCount] = '{1, 0, 8, 15, 9, 3, 0};

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [DataW-1:0]     s_axis_tdata  = '0;
  logic [ChannelW-1:0]  s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [DataW-1:0]     m_axis_tdata;
  logic [ChannelW-1:0]  m_axis_tuser;
  logic                 psel          = 1'b0;
  logic                 penable       = 1'b0;
  logic                 pwrite        = 1'b0;
  logic [ApbAddrW-1:0]  paddr         = '0;
  logic [ApbDataW-1:0]  pwdata        = '0;
  logic [ApbDataW-1:0]  prdata;
  logic                 pready;

  trimmed_mean_adc_filter_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk_i = ~clk_i;

  // Samples waiting to be offered, and filtered values waiting to come out.
  adc_sample_t     pending_samples [$];
  filtered_value_t pending_values  [$];

  // Shadow of the filter: gain register and one running block per channel.
  logic [GainW-1:0]   gain_shadow = GainReset;
  logic [CountW-1:0]  block_count [Channels];
  logic [SumW-1:0]    block_sum   [Channels];
  logic [SampleW-1:0] block_min   [Channels];
  logic [SampleW-1:0] block_max   [Channels];

  int unsigned mismatch_count  = 0;
  int unsigned samples_sent    = 0;
  int unsigned values_checked  = 0;
  int unsigned values_clipped  = 0;
  int unsigned gains_used      = 1;
  int unsigned burst_left      = 0;
  int unsigned gap_left        = 0;
  int unsigned hold_requests   = 0;
  int unsigned holds_served    = 0;
  int unsigned hold_left       = 0;
  int unsigned stall_span      = 0;
  int unsigned stall_mode      = 0;
  int unsigned idle_cycles     = 0;
  adc_sample_t     next_sample;
  filtered_value_t oldest_value;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic clear_block(input int unsigned ch);
    block_count[ch] = '0;
    block_sum[ch]   = '0;
    block_min[ch]   = SampleMax;
    block_max[ch]   = '0;
  endtask

  // Folds one sample into its channel's block; the tenth sample yields the
  // gain times the truncated mean of the eight middle samples, clipped to 15 bits.
  task automatic filter_sample(input adc_sample_t item);
    int unsigned     ch;
    logic [SumW-1:0] trimmed;
    logic [16:0]     product;
    filtered_value_t result;
    ch = 32'(item.channel);
    if (ch < Channels) begin
      block_sum[ch]   = block_sum[ch] + SumW'(item.sample);
      if (item.sample < block_min[ch]) block_min[ch] = item.sample;
      if (item.sample > block_max[ch]) block_max[ch] = item.sample;
      block_count[ch] = block_count[ch] + CountW'(1);
      if (block_count[ch] == BlockLen) begin
        trimmed        = block_sum[ch] - SumW'(block_min[ch]) - SumW'(block_max[ch]);
        product        = 17'(trimmed >> KeptShift) * 17'(gain_shadow);
        result.channel = item.channel;
        result.value   = (product > 17'(ValueMax)) ? ValueMax : product[ValueW-1:0];
        pending_values.push_back(result);
        clear_block(ch);
      end
    end
  endtask

  // Mostly uniform samples, with some near either end of the range.
  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return SampleW'($urandom_range(0, 15));
      1:       return SampleW'($urandom_range(4080, 4095));
      2:       return SampleW'($urandom_range(3600, 4095));
      default: return SampleW'($urandom_range(0, 4095));
    endcase
  endfunction

  // Sender: bursts of random length with random gaps, fed from the pending queue.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || s_axis_tready) begin
      if (gap_left != 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_samples.size() != 0) begin
        next_sample = pending_samples.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= DataW'(next_sample.sample);
        s_axis_tuser  <= next_sample.channel;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: stall modes that change at random, plus long hold-offs on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HoldCycles;
      m_axis_tready <= 1'b0;
    end else begin
      if (stall_span == 0) begin
        stall_span = $urandom_range(8, 64);
        stall_mode = $urandom_range(0, 3);
      end else begin
        stall_span--;
      end
      case (stall_mode)
        0:       m_axis_tready <= 1'b1;
        1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
        2:       m_axis_tready <= ($urandom_range(0, 1) != 0);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: checks each output transfer against the oldest expected value,
  // predicts from each input transfer and tracks the gain register.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_values.size() == 0) begin
          report_mismatch($sformatf("unexpected result: channel %0d value %0d",
                                    m_axis_tuser, m_axis_tdata[ValueW-1:0]));
        end else begin
          oldest_value = pending_values.pop_front();
          if (m_axis_tuser !== oldest_value.channel)
            report_mismatch($sformatf("channel %0d, expected %0d",
                                      m_axis_tuser, oldest_value.channel));
          if (m_axis_tdata[ValueW-1:0] !== oldest_value.value)
            report_mismatch($sformatf("channel %0d value %0d, expected %0d",
                                      oldest_value.channel, m_axis_tdata[ValueW-1:0],
                                      oldest_value.value));
          values_checked++;
          if (oldest_value.value == ValueMax) values_clipped++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        filter_sample('{channel: s_axis_tuser, sample: s_axis_tdata[SampleW-1:0]});
        samples_sent++;
      end
      if (psel && penable && pready && paddr == GainAddr) begin
        if (pwrite) begin
          gain_shadow = pwdata[GainW-1:0];
        end else if (prdata !== ApbDataW'(gain_shadow)) begin
          report_mismatch($sformatf("gain read %0d, expected %0d", prdata, gain_shadow));
        end
      end
    end
  end

  // Watchdog: ends the run when no transfer of any kind happens for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no transfer for %0d cycles", IdleLimit);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // One register access: a setup phase, then an access phase.
  task automatic gain_access(input logic is_write, input logic [ApbDataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= GainAddr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Holds the sender back until every expected value has come out, then lets
  // samples that complete no block finish their update.
  task automatic wait_drained();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid || pending_values.size() != 0);
    repeat (SettleWait) @(negedge clk_i);
  endtask

  initial begin
    logic [GainW-1:0]    gain;
    logic [ChannelW-1:0] channel;
    for (int ch = 0; ch < Channels; ch++) clear_block(ch);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    gain_access(1'b0, '0);

    // Directed part: channel 0 sees both ends of the range and alternating bit
    // patterns, channel 1 a block of equal full-scale samples, so that the
    // dropped minimum and maximum tie; channels 2 and 3 start partial blocks.
    begin
      logic [SampleW-1:0] edge_samples [10] = '{12'h000, 12'hFFF, 12'hAAA, 12'h555, 12'h001,
                                                 12'h800, 12'hFFE, 12'h7FF, 12'h400, 12'h064};
      for (int i = 0; i < 10; i++) begin
        pending_samples.push_back('{channel: ChannelW'(0), sample: edge_samples[i]});
        pending_samples.push_back('{channel: ChannelW'(1), sample: SampleMax});
      end
    end
    pending_samples.push_back('{channel: ChannelW'(2), sample: '0});
    pending_samples.push_back('{channel: ChannelW'(3), sample: SampleMax});
    pending_samples.push_back('{channel: ChannelW'(2), sample: SampleMax});
    pending_samples.push_back('{channel: ChannelW'(3), sample: '0});

    channel = '0;
    for (int p = 0; p < PhaseCount; p++) begin
      if (p > 0) begin
        wait_drained();
        // The last phase runs at a random gain, above the intended range included.
        gain = (p == PhaseCount - 1) ? GainW'($urandom_range(0, 15)) : GainW'(GainPlan[p]);
        gain_access(1'b1, ApbDataW'(gain));
        gain_access(1'b0, '0);
        gains_used++;
      end
      if (p == HoldPhase) hold_requests++;
      // Half the time a sample draws a new random channel, else it stays on the previous
      // channel, so that blocks of one channel complete back to back.
      for (int i = 0; i < PhaseItems; i++) begin
        if ($urandom_range(0, 1) == 0) channel = ChannelW'($urandom_range(0, Channels - 1));
        pending_samples.push_back('{channel: channel, sample: pick_sample()});
      end
    end
    wait_drained();

    $display("Run covered %0d samples on %0d channels at %0d gain settings.",
             samples_sent, Channels, gains_used);
    $display("Checked %0d filtered values, %0d of them at the 15-bit ceiling.",
             values_checked, values_clipped);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
